// ----- rtl/core/indexed_list_engine_defines.svh -----
// ----------------------------------------------------------------------------
// Indexed list engine assertion macros
// Concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define ILE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define ILE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ILE_ASSERT(lbl, prop, msg)
`define ILE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/core/ile_pkg.sv -----
// ----------------------------------------------------------------------------
// Indexed list engine package
// Sizes, request and status codes, and the command broadcast to the cells.
// ----------------------------------------------------------------------------
package ile_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 6;
	localparam int WORD_W   = 32;
	localparam int MODE_W   = 3;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 7;
	// wide enough for both a position and a fill count
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_APPEND = 3'd0,
		MODE_INSERT = 3'd1,
		MODE_READ   = 3'd2,
		MODE_WRITE  = 3'd3,
		MODE_REMOVE = 3'd4,
		MODE_FIND   = 3'd5,
		MODE_CLEAR  = 3'd6
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_RANGE   = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_MISSING = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_SQUEEZE
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [CMP_W-1:0]  pos;
		logic [CMP_W-1:0]  fill;
		word_t             word;
	} cell_cmd_t;

endpackage

// ----- rtl/core/ile_ifs.sv -----
// ----------------------------------------------------------------------------
// Indexed list engine channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
interface ile_req_if;
	logic                           valid;
	logic                           ready;
	logic [ile_pkg::MODE_W-1:0]     mode;
	logic [ile_pkg::POS_W-1:0]      position;
	logic signed [ile_pkg::WORD_W-1:0] word;

	modport source (output valid, output mode, output position, output word, input ready);
	modport sink   (input valid, input mode, input position, input word, output ready);
endinterface

interface ile_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [ile_pkg::WORD_W-1:0] read_word;
	logic [ile_pkg::STATUS_W-1:0]      status;
	logic [ile_pkg::LEN_W-1:0]         length;

	modport source (output valid, output read_word, output status, output length, input ready);
	modport sink   (input valid, input read_word, input status, input length, output ready);
endinterface

// ----- rtl/core/ile_cell.sv -----
// ----------------------------------------------------------------------------
// Indexed list engine cell
// One list entry: loads, takes a neighbor's word, or holds; flags a match.
// ----------------------------------------------------------------------------
module ile_cell (
	input  logic                       clk,
	input  logic [ile_pkg::CMP_W-1:0]  idx,
	input  ile_pkg::cell_cmd_t         cmd,
	input  ile_pkg::word_t             left,
	input  ile_pkg::word_t             right,
	input  logic                       squeeze,
	output ile_pkg::word_t             data,
	output logic                       hit
);

	ile_pkg::word_t data_q;
	ile_pkg::word_t data_nxt;

	always_comb begin
		data_nxt = data_q;
		case (cmd.op)
			ile_pkg::CELL_LOAD: begin
				if (idx == cmd.pos) data_nxt = cmd.word;
			end
			ile_pkg::CELL_INSERT: begin
				if (idx == cmd.pos) data_nxt = cmd.word;
				else if (idx > cmd.pos) data_nxt = left;
			end
			ile_pkg::CELL_REMOVE: begin
				if (idx >= cmd.pos) data_nxt = right;
			end
			ile_pkg::CELL_SQUEEZE: begin
				if (squeeze) data_nxt = right;
			end
			default: data_nxt = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

	assign data = data_q;
	assign hit  = (data_q == cmd.word) && (idx < cmd.fill);

endmodule

// ----- rtl/core/ile_chain.sv -----
// ----------------------------------------------------------------------------
// Indexed list engine cell chain
// Row of entry cells linked to their neighbors, the first-match prefix and
// the read selector.
// ----------------------------------------------------------------------------
module ile_chain (
	input  logic                          clk,
	input  ile_pkg::cell_cmd_t            cmd,
	input  logic [ile_pkg::CAPACITY-1:0]  sel,
	input  logic [ile_pkg::IDX_W-1:0]     rd_pos,
	output ile_pkg::word_t                rd_data,
	output logic [ile_pkg::CAPACITY-1:0]  hits
);

	ile_pkg::word_t                 data [ile_pkg::CAPACITY];
	logic [ile_pkg::CAPACITY-1:0]   pre;

	// every cell at or above the first selected one moves down
	always_comb begin
		pre = sel;
		for (int l = 0; l < ile_pkg::IDX_W; l++) begin
			pre = pre | (pre << (1 << l));
		end
	end

	for (genvar i = 0; i < ile_pkg::CAPACITY; i++) begin : g_cell
		ile_pkg::word_t left;
		ile_pkg::word_t right;

		if (i == 0) begin : g_first
			assign left = cmd.word;
		end else begin : g_left
			assign left = data[i-1];
		end

		if (i == ile_pkg::CAPACITY - 1) begin : g_last
			assign right = data[i];
		end else begin : g_right
			assign right = data[i+1];
		end

		ile_cell u_cell (
			.clk     (clk),
			.idx     (ile_pkg::CMP_W'(i)),
			.cmd     (cmd),
			.left    (left),
			.right   (right),
			.squeeze (pre[i]),
			.data    (data[i]),
			.hit     (hits[i])
		);
	end

	assign rd_data = data[rd_pos];

endmodule

// ----- rtl/core/indexed_list_engine.sv -----
// ----------------------------------------------------------------------------
// Indexed list engine
// Ordered list of signed words with append, insert, read, overwrite,
// remove at index, remove by value and clear.
// ----------------------------------------------------------------------------
// Requests arrive on req (mode, position, word); each gives exactly one
// response on rsp (read_word, status, length), in request order.
// The list lives in a chain of CAPACITY cells, one entry each. Insert and
// remove move every affected cell to its neighbor's word in the same cycle.
// Append, insert, read, overwrite, remove at index and clear take one cycle:
// the response is registered at the edge that accepts the request, and a
// new request may be taken in every cycle.
// Remove by value first registers the compare of all cells against the word,
// then closes the gap at the first match once the output register is free.
// The output register is the only buffer: while a response waits and rsp is
// stalled, req.ready stays low; it rises in the cycle that rsp takes it.
// Reset empties the list (length zero) and clears any pending response; the
// entry contents are not cleared and are never visible before written.
// ----------------------------------------------------------------------------
`include "indexed_list_engine_defines.svh"

module indexed_list_engine (
	input  logic         clk,
	input  logic         arst_n,
	ile_req_if.sink      req,
	ile_rsp_if.source    rsp
);

	typedef enum logic {
		ST_RUN,
		ST_SQUEEZE
	} state_t;

	state_t                          state_q;
	logic [ile_pkg::CNT_W-1:0]       fill_q;
	logic [ile_pkg::CAPACITY-1:0]    match_q;
	ile_pkg::word_t                  word_q;
	logic                            out_valid_q;
	ile_pkg::word_t                  read_word_q;
	ile_pkg::status_t                status_q;
	logic [ile_pkg::LEN_W-1:0]       length_q;

	logic                            out_free;
	logic                            accept;
	logic [ile_pkg::CMP_W-1:0]       pos_w;
	logic [ile_pkg::CMP_W-1:0]       fill_w;
	logic                            full;
	ile_pkg::cell_cmd_t              cmd;
	ile_pkg::word_t                  rd_data;
	logic [ile_pkg::CAPACITY-1:0]    hits;
	logic                            fire;
	logic                            search;
	ile_pkg::word_t                  res_word;
	ile_pkg::status_t                res_status;
	logic [ile_pkg::CNT_W-1:0]       res_fill;

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_RUN) && out_free;
	assign accept    = req.valid && req.ready;
	assign pos_w     = ile_pkg::CMP_W'(req.position);
	assign fill_w    = ile_pkg::CMP_W'(fill_q);
	assign full      = (fill_q == ile_pkg::CNT_W'(ile_pkg::CAPACITY));

	always_comb begin
		cmd.op     = ile_pkg::CELL_HOLD;
		cmd.pos    = pos_w;
		cmd.fill   = fill_w;
		cmd.word   = req.word;
		fire       = 1'b0;
		search     = 1'b0;
		res_word   = '0;
		res_status = ile_pkg::STAT_OK;
		res_fill   = fill_q;
		if (state_q == ST_SQUEEZE) begin
			if (out_free) begin
				fire = 1'b1;
				if (|match_q) begin
					cmd.op   = ile_pkg::CELL_SQUEEZE;
					res_word = word_q;
					res_fill = fill_q - ile_pkg::CNT_W'(1);
				end else begin
					res_status = ile_pkg::STAT_MISSING;
				end
			end
		end else if (accept) begin
			fire = 1'b1;
			case (ile_pkg::mode_t'(req.mode))
				ile_pkg::MODE_APPEND: begin
					if (full) begin
						res_status = ile_pkg::STAT_FULL;
					end else begin
						cmd.op   = ile_pkg::CELL_LOAD;
						cmd.pos  = fill_w;
						res_fill = fill_q + ile_pkg::CNT_W'(1);
					end
				end
				ile_pkg::MODE_INSERT: begin
					if (full) begin
						res_status = ile_pkg::STAT_FULL;
					end else if (pos_w > fill_w) begin
						res_status = ile_pkg::STAT_RANGE;
					end else begin
						cmd.op   = ile_pkg::CELL_INSERT;
						res_fill = fill_q + ile_pkg::CNT_W'(1);
					end
				end
				ile_pkg::MODE_READ: begin
					if (pos_w >= fill_w) res_status = ile_pkg::STAT_RANGE;
					else res_word = rd_data;
				end
				ile_pkg::MODE_WRITE: begin
					if (pos_w >= fill_w) res_status = ile_pkg::STAT_RANGE;
					else cmd.op = ile_pkg::CELL_LOAD;
				end
				ile_pkg::MODE_REMOVE: begin
					if (pos_w >= fill_w) begin
						res_status = ile_pkg::STAT_RANGE;
					end else begin
						cmd.op   = ile_pkg::CELL_REMOVE;
						res_word = rd_data;
						res_fill = fill_q - ile_pkg::CNT_W'(1);
					end
				end
				ile_pkg::MODE_FIND: begin
					// register the compare now, answer once the output register is free
					fire   = 1'b0;
					search = 1'b1;
				end
				ile_pkg::MODE_CLEAR: begin
					res_fill = '0;
				end
				default: begin
					res_fill = fill_q;
				end
			endcase
		end
	end

	ile_chain u_chain (
		.clk     (clk),
		.cmd     (cmd),
		.sel     (match_q),
		.rd_pos  (pos_w[ile_pkg::IDX_W-1:0]),
		.rd_data (rd_data),
		.hits    (hits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			fill_q      <= '0;
			match_q     <= '0;
			word_q      <= '0;
			out_valid_q <= 1'b0;
			read_word_q <= '0;
			status_q    <= ile_pkg::STAT_OK;
			length_q    <= '0;
		end else begin
			if (search) begin
				state_q <= ST_SQUEEZE;
				match_q <= hits;
				word_q  <= req.word;
			end else if (fire) begin
				state_q <= ST_RUN;
			end
			if (fire) begin
				fill_q      <= res_fill;
				out_valid_q <= 1'b1;
				read_word_q <= res_word;
				status_q    <= res_status;
				length_q    <= ile_pkg::LEN_W'(res_fill);
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.read_word = read_word_q;
	assign rsp.status    = status_q;
	assign rsp.length    = length_q;

	`ILE_ASSERT(a_fill_bound, fill_q <= ile_pkg::CNT_W'(ile_pkg::CAPACITY), "fill beyond capacity")
	`ILE_ASSERT(a_squeeze_blocks, (state_q != ST_SQUEEZE) || !req.ready, "request taken during search")
	`ILE_ASSERT_NEXT(a_find_enters, accept && (req.mode == ile_pkg::MODE_FIND), state_q == ST_SQUEEZE, "search not started")
	`ILE_ASSERT(a_length_tracks, !out_valid_q || (length_q == ile_pkg::LEN_W'(fill_q)), "length differs from fill")
	`ILE_ASSERT(a_full_len, !(out_valid_q && (status_q == ile_pkg::STAT_FULL)) || (fill_q == ile_pkg::CNT_W'(ile_pkg::CAPACITY)), "full status below capacity")

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// Indexed list engine testbench
// Drives requests through the req channel with random gaps and checks each
// response on rsp against a behavioral copy of the list kept alongside it.
// ----------------------------------------------------------------------------

typedef struct {
	ile_pkg::word_t                 read_word;
	ile_pkg::status_t               status;
	logic [ile_pkg::LEN_W-1:0]      length;
} list_result_t;

class list_scoreboard;
	ile_pkg::word_t slots[ile_pkg::CAPACITY];
	int unsigned    fill;
	list_result_t   results_q[$];
	int unsigned    failures;
	int unsigned    checked;
	int unsigned    peak;
	int unsigned    outcome_count[4];

	function int unsigned length_now();
		return fill;
	endfunction

	function int unsigned outstanding();
		return results_q.size();
	endfunction

	function ile_pkg::word_t pick_stored();
		if (fill == 0)
			return ile_pkg::word_t'($urandom);
		return slots[$urandom_range(0, fill - 1)];
	endfunction

	function void close_gap(int unsigned at);
		int unsigned idx;
		for (idx = at; idx + 1 < fill; idx++)
			slots[idx] = slots[idx + 1];
		fill--;
	endfunction

	// Apply one accepted transaction to the list and queue its response.
	function void note_request(logic [ile_pkg::MODE_W-1:0] m,
			logic [ile_pkg::POS_W-1:0] p, ile_pkg::word_t w);
		list_result_t r;
		int unsigned  idx;
		int           hit;
		r.read_word = '0;
		r.status    = ile_pkg::STAT_OK;
		case (m)
			ile_pkg::MODE_APPEND: begin
				if (fill >= ile_pkg::CAPACITY) begin
					r.status = ile_pkg::STAT_FULL;
				end else begin
					slots[fill] = w;
					fill++;
				end
			end
			ile_pkg::MODE_INSERT: begin
				// full takes precedence over the index check
				if (fill >= ile_pkg::CAPACITY) begin
					r.status = ile_pkg::STAT_FULL;
				end else if (p > fill) begin
					r.status = ile_pkg::STAT_RANGE;
				end else begin
					for (idx = fill; idx > p; idx--)
						slots[idx] = slots[idx - 1];
					slots[p] = w;
					fill++;
				end
			end
			ile_pkg::MODE_READ: begin
				if (p >= fill)
					r.status = ile_pkg::STAT_RANGE;
				else
					r.read_word = slots[p];
			end
			ile_pkg::MODE_WRITE: begin
				if (p >= fill)
					r.status = ile_pkg::STAT_RANGE;
				else
					slots[p] = w;
			end
			ile_pkg::MODE_REMOVE: begin
				if (p >= fill) begin
					r.status = ile_pkg::STAT_RANGE;
				end else begin
					r.read_word = slots[p];
					close_gap(p);
				end
			end
			ile_pkg::MODE_FIND: begin
				hit = -1;
				for (idx = 0; idx < fill; idx++)
					if (hit < 0 && slots[idx] == w)
						hit = idx;
				if (hit < 0) begin
					r.status = ile_pkg::STAT_MISSING;
				end else begin
					r.read_word = slots[hit];
					close_gap(hit);
				end
			end
			ile_pkg::MODE_CLEAR: begin
				fill = 0;
			end
			default: begin
			end
		endcase
		r.length = ile_pkg::LEN_W'(fill);
		if (fill > peak)
			peak = fill;
		outcome_count[r.status]++;
		results_q.push_back(r);
	endfunction

	function void check_response(ile_pkg::word_t got_word,
			logic [ile_pkg::STATUS_W-1:0] got_status, logic [ile_pkg::LEN_W-1:0] got_length);
		list_result_t r;
		checked++;
		if (results_q.size() == 0) begin
			$error("response with no request outstanding: read_word %0d status %0d length %0d",
				got_word, got_status, got_length);
			failures++;
			return;
		end
		r = results_q.pop_front();
		if (got_word !== r.read_word) begin
			$error("read_word: expected %0d, got %0d", r.read_word, got_word);
			failures++;
		end
		if (got_status !== r.status) begin
			$error("status: expected %0d, got %0d", r.status, got_status);
			failures++;
		end
		if (got_length !== r.length) begin
			$error("length: expected %0d, got %0d", r.length, got_length);
			failures++;
		end
	endfunction
endclass

module tb;
	import ile_pkg::*;

	localparam int unsigned         CYCLE_LIMIT  = 200000;
	localparam int unsigned         RANDOM_ITEMS = 500;
	localparam int unsigned         LONG_HOLD    = 60;
	localparam logic [MODE_W-1:0]   MODE_UNUSED  = 3'd7;
	localparam word_t               WORD_MAX     = 32'sh7FFF_FFFF;
	localparam word_t               WORD_MIN     = 32'sh8000_0000;

	typedef enum {
		PROFILE_FILL,
		PROFILE_GROW,
		PROFILE_SHRINK,
		PROFILE_MIXED
	} mix_t;

	logic clk = 1'b0;
	logic arst_n;

	ile_req_if req_ch ();
	ile_rsp_if rsp_ch ();

	indexed_list_engine u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	list_scoreboard list_sb = new;

	bit          steady;
	int unsigned hold_off;
	int unsigned cycle_count;
	int unsigned sent;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_request(input logic [MODE_W-1:0] m, input logic [POS_W-1:0] p,
			input word_t w);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.mode     <= m;
		req_ch.position <= p;
		req_ch.word     <= w;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		list_sb.note_request(m, p, w);
		sent++;
	endtask

	task automatic random_request(input mix_t profile);
		int unsigned         roll;
		int unsigned         n;
		logic [MODE_W-1:0]   m;
		logic [POS_W-1:0]    p;
		word_t               w;
		n    = list_sb.length_now();
		roll = $urandom_range(0, 99);
		case (profile)
			PROFILE_FILL: m = (roll < 50) ? MODE_APPEND : MODE_INSERT;
			PROFILE_GROW: begin
				if (roll < 35)      m = MODE_APPEND;
				else if (roll < 70) m = MODE_INSERT;
				else if (roll < 80) m = MODE_READ;
				else if (roll < 90) m = MODE_WRITE;
				else if (roll < 95) m = MODE_REMOVE;
				else                m = MODE_FIND;
			end
			PROFILE_SHRINK: begin
				if (roll < 35)      m = MODE_REMOVE;
				else if (roll < 70) m = MODE_FIND;
				else if (roll < 80) m = MODE_READ;
				else if (roll < 90) m = MODE_WRITE;
				else if (roll < 95) m = MODE_APPEND;
				else                m = MODE_INSERT;
			end
			default: begin
				if (roll < 16)      m = MODE_APPEND;
				else if (roll < 32) m = MODE_INSERT;
				else if (roll < 48) m = MODE_READ;
				else if (roll < 64) m = MODE_WRITE;
				else if (roll < 80) m = MODE_REMOVE;
				else if (roll < 96) m = MODE_FIND;
				else if (roll < 98) m = MODE_CLEAR;
				else                m = MODE_UNUSED;
			end
		endcase
		// mostly legal positions, some anywhere in the field
		if ($urandom_range(0, 4) == 0)
			p = POS_W'($urandom_range(0, (1 << POS_W) - 1));
		else if (m == MODE_INSERT)
			p = POS_W'($urandom_range(0, (n > (1 << POS_W) - 1) ? (1 << POS_W) - 1 : n));
		else
			p = (n == 0) ? '0 : POS_W'($urandom_range(0, n - 1));
		roll = $urandom_range(0, 99);
		if (m == MODE_FIND && n != 0 && roll < 70)
			w = list_sb.pick_stored();
		else if (roll < 25)
			w = word_t'($urandom_range(0, 4)) - 2;
		else if (roll < 30)
			w = roll[0] ? WORD_MAX : WORD_MIN;
		else
			w = word_t'($urandom);
		send_request(m, p, w);
	endtask

	initial begin
		int unsigned gap;
		rsp_ch.ready <= 1'b0;
		do @(posedge clk); while (arst_n !== 1'b1);
		forever begin
			gap = steady ? 0 : $urandom_range(0, 4);
			if (hold_off != 0) begin
				gap      = hold_off;
				hold_off = 0;
			end
			if (gap != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
			list_sb.check_response(rsp_ch.read_word, rsp_ch.status, rsp_ch.length);
		end
	end

	initial begin
		int unsigned round_len;
		mix_t        profile;
		req_ch.valid    <= 1'b0;
		req_ch.mode     <= MODE_APPEND;
		req_ch.position <= '0;
		req_ch.word     <= '0;
		arst_n          <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: read, remove, find and write all miss; then three entries go in
		send_request(MODE_READ,   0, 0);
		send_request(MODE_REMOVE, 0, 0);
		send_request(MODE_FIND,   0, 5);
		send_request(MODE_WRITE,  0, 99);
		send_request(MODE_APPEND, 0, WORD_MAX);
		send_request(MODE_APPEND, 0, WORD_MIN);
		send_request(MODE_INSERT, 0, -1);
		// insert at the current length behaves as append; one past is rejected
		send_request(MODE_INSERT, 3, 0);
		send_request(MODE_INSERT, 5, 1);
		send_request(MODE_READ,   0, 0);
		send_request(MODE_READ,   3, 0);
		send_request(MODE_READ,   4, 0);
		send_request(MODE_WRITE,  1, 7);
		send_request(MODE_WRITE,  4, 8);
		send_request(MODE_REMOVE, 4, 0);
		send_request(MODE_REMOVE, 1, 0);
		send_request(MODE_APPEND, 0, -1);
		send_request(MODE_FIND,   0, -1);
		send_request(MODE_FIND,   0, 12345);
		send_request(MODE_UNUSED, 63, WORD_MIN);
		send_request(MODE_CLEAR,  0, 0);
		send_request(MODE_READ,   0, 0);
		send_request(MODE_FIND,   0, 0);

		// fill to capacity against a long receiver stall, then hit the full checks
		hold_off = LONG_HOLD;
		steady   = 1'b1;
		while (list_sb.length_now() < CAPACITY)
			random_request(PROFILE_FILL);
		steady = 1'b0;
		send_request(MODE_APPEND, 0,  word_t'($urandom));
		send_request(MODE_INSERT, 0,  word_t'($urandom));
		send_request(MODE_INSERT, 63, word_t'($urandom));
		send_request(MODE_READ,   63, 0);
		send_request(MODE_WRITE,  63, WORD_MIN);

		// let everything drain before continuing
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (list_sb.outstanding() != 0);

		while (list_sb.length_now() > 4)
			random_request(PROFILE_SHRINK);

		while (sent < RANDOM_ITEMS + 25) begin
			steady    = ($urandom_range(0, 3) == 0);
			round_len = $urandom_range(20, 60);
			case ($urandom_range(0, 2))
				0:       profile = PROFILE_GROW;
				1:       profile = (list_sb.length_now() < 8) ? PROFILE_MIXED : PROFILE_SHRINK;
				default: profile = PROFILE_MIXED;
			endcase
			repeat (round_len) random_request(profile);
		end

		steady = 1'b0;
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (list_sb.outstanding() != 0);
		// catch any stray response
		repeat (6) @(posedge clk);

		$display("Sent %0d requests, checked %0d responses, list length peaked at %0d",
			sent, list_sb.checked, list_sb.peak);
		$display("Outcomes: %0d ok, %0d out of range, %0d full, %0d value not found",
			list_sb.outcome_count[STAT_OK], list_sb.outcome_count[STAT_RANGE],
			list_sb.outcome_count[STAT_FULL], list_sb.outcome_count[STAT_MISSING]);
		if (list_sb.failures == 0 && list_sb.outstanding() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
